// ===== design/lcdfs_pkg.sv =====
package lcdfs_pkg;

  // Beat kinds carried on the input tuser
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_DESC  = 2'd3;

  // Frame sequencer states
  localparam logic [1:0] FS_IDLE  = 2'd0;
  localparam logic [1:0] FS_START = 2'd1;
  localparam logic [1:0] FS_END   = 2'd2;
  localparam logic [1:0] FS_FETCH = 2'd3;

  // Register word indexes (byte offset >> 2)
  localparam logic [7:0] IDX_CTRL0   = 8'd0;
  localparam logic [7:0] IDX_CTRL3   = 8'd3;
  localparam logic [7:0] IDX_BRANCH0 = 8'd8;
  localparam logic [7:0] IDX_BRANCH1 = 8'd9;
  localparam logic [7:0] IDX_STATUS  = 8'd14;
  localparam logic [7:0] IDX_MISC0   = 8'd15;
  localparam logic [7:0] IDX_MISC2   = 8'd17;
  localparam logic [7:0] IDX_DESC0   = 8'd128;
  localparam logic [7:0] IDX_DESC4   = 8'd132;
  localparam logic [7:0] IDX_DESC7   = 8'd135;

  // Status bits
  localparam logic [15:0] STAT_SOF       = 16'h0002;
  localparam logic [15:0] STAT_QUICK_DIS = 16'h0080;
  localparam logic [15:0] STAT_EOF       = 16'h0100;
  localparam logic [15:0] STAT_BRANCH    = 16'h0200;

  localparam logic [15:0] MASK_BASE = 16'h7C8E;

  // Descriptor command bits
  localparam int unsigned CMD_SOF_BIT = 22;
  localparam int unsigned CMD_EOF_BIT = 21;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  byte_offset;
    logic        word_access;
    logic [31:0] data_in;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        fetch_request;
    logic [31:0] fetch_address;
  } result_t;

  // Interrupt mask rebuilt from a control register 0 write value
  function automatic logic [15:0] ctrl0_mask(input logic [31:0] v);
    logic [15:0] m;
    m = MASK_BASE;
    if (v[21]) m = m | 16'h0040;
    if (v[20]) m = m | 16'h0200;
    if (v[10]) m = m | 16'h0001;
    if (v[6])  m = m | 16'h0080;
    if (v[5])  m = m | 16'h0030;
    if (v[4])  m = m | 16'h0002;
    return m;
  endfunction

endpackage

// ===== design/lcdfs_regs.sv =====
module lcdfs_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             proc,
  input  lcdfs_pkg::item_t item,
  output lcdfs_pkg::result_t res
);
  import lcdfs_pkg::*;

  logic [31:0] ctrl_r [4];
  logic [31:0] ctrl_nxt [4];
  logic [31:0] branch_r [2];
  logic [31:0] branch_nxt [2];
  logic [31:0] misc_r [3];
  logic [31:0] misc_nxt [3];
  logic [31:0] desc_r [8];
  logic [31:0] desc_nxt [8];
  logic [15:0] status_r, status_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic        en_chg_r, en_chg_nxt;
  logic [1:0]  state_r, state_nxt;
  logic [1:0]  count_r, count_nxt;
  logic [31:0] base_r, base_nxt;

  logic [7:0]  idx;
  logic [7:0]  misc_off;
  logic [1:0]  misc_sel;
  logic [1:0]  count_inc;
  logic [31:0] rd;
  logic        req;
  logic [31:0] addr;

  assign idx       = item.byte_offset[9:2];
  assign misc_off  = idx - IDX_MISC0;
  assign misc_sel  = misc_off[1:0];
  assign count_inc = count_r + 2'd1;

  always_comb begin
    ctrl_nxt   = ctrl_r;
    branch_nxt = branch_r;
    misc_nxt   = misc_r;
    desc_nxt   = desc_r;
    status_nxt = status_r;
    mask_nxt   = mask_r;
    en_chg_nxt = en_chg_r;
    state_nxt  = state_r;
    count_nxt  = count_r;
    base_nxt   = base_r;
    rd         = '0;
    req        = 1'b0;
    addr       = '0;

    case (item.mode)
      MODE_READ: begin
        if (item.word_access) begin
          if (idx inside {[IDX_CTRL0:IDX_CTRL3]}) rd = ctrl_r[idx[1:0]];
          else if (idx inside {IDX_BRANCH0, IDX_BRANCH1}) rd = branch_r[idx[0]];
          else if (idx == IDX_STATUS) rd = {16'd0, status_r};
          else if (idx inside {[IDX_MISC0:IDX_MISC2]}) rd = misc_r[misc_sel];
          else if (idx inside {[IDX_DESC0:IDX_DESC7]}) rd = desc_r[idx[2:0]];
        end
      end
      MODE_WRITE: begin
        if (item.word_access) begin
          if (idx == IDX_CTRL0) begin
            if (ctrl_r[0][0] != item.data_in[0]) en_chg_nxt = 1'b1;
            ctrl_nxt[0] = item.data_in;
            mask_nxt    = ctrl0_mask(item.data_in);
          end else if (idx inside {[IDX_CTRL0:IDX_CTRL3]}) begin
            ctrl_nxt[idx[1:0]] = item.data_in;
          end else if (idx inside {IDX_BRANCH0, IDX_BRANCH1}) begin
            branch_nxt[idx[0]] = item.data_in;
          end else if (idx == IDX_STATUS) begin
            status_nxt = status_r & ~item.data_in[15:0];
          end else if (idx inside {[IDX_MISC0:IDX_MISC2]}) begin
            misc_nxt[misc_sel] = item.data_in;
          end else if (idx == IDX_DESC0) begin
            desc_nxt[0] = item.data_in;
          end else if (idx == IDX_DESC4) begin
            desc_nxt[4] = item.data_in;
          end
        end
      end
      MODE_TICK: begin
        if (state_r != FS_FETCH) begin
          // quick disable
          if (en_chg_r) begin
            en_chg_nxt = 1'b0;
            if (!ctrl_r[0][0]) begin
              status_nxt = status_nxt | STAT_QUICK_DIS;
              state_nxt  = FS_IDLE;
            end
          end
          if (ctrl_r[0][0]) begin
            case (state_r)
              FS_IDLE: begin
                if (branch_r[0][0]) begin
                  branch_nxt[0] = {branch_r[0][31:1], 1'b0};
                  if (branch_r[0][1]) status_nxt = status_nxt | STAT_BRANCH;
                  addr = {branch_r[0][31:4], 4'd0};
                end else begin
                  addr = desc_r[0];
                end
                base_nxt  = addr;
                count_nxt = 2'd0;
                state_nxt = FS_FETCH;
                req       = 1'b1;
              end
              FS_START: begin
                if (desc_r[3][CMD_SOF_BIT]) status_nxt = status_nxt | STAT_SOF;
                state_nxt = FS_END;
              end
              default: begin
                if (desc_r[3][CMD_EOF_BIT]) status_nxt = status_nxt | STAT_EOF;
                state_nxt = FS_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        if (state_r == FS_FETCH) begin
          desc_nxt[{1'b0, count_r}] = item.data_in;
          if (count_r == 2'd3) begin
            count_nxt = 2'd0;
            state_nxt = FS_START;
          end else begin
            count_nxt = count_inc;
            addr      = base_r + {28'd0, count_inc, 2'b00};
            req       = 1'b1;
          end
        end
      end
    endcase

    res.read_data     = rd;
    res.irq           = |(status_nxt & mask_nxt);
    res.fetch_request = req;
    res.fetch_address = addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '{default: '0};
      branch_r <= '{default: '0};
      misc_r   <= '{default: '0};
      desc_r   <= '{default: '0};
      status_r <= '0;
      mask_r   <= MASK_BASE;
      en_chg_r <= 1'b0;
      state_r  <= FS_IDLE;
      count_r  <= '0;
      base_r   <= '0;
    end else if (proc) begin
      ctrl_r   <= ctrl_nxt;
      branch_r <= branch_nxt;
      misc_r   <= misc_nxt;
      desc_r   <= desc_nxt;
      status_r <= status_nxt;
      mask_r   <= mask_nxt;
      en_chg_r <= en_chg_nxt;
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      base_r   <= base_nxt;
    end
  end

endmodule

// ===== design/lcd_controller_registers_frame_seq_core.sv =====
// Channel | Dir | Handshake            | Payload
// in_     | in  | in_tvalid/in_tready   | tuser: mode[1:0]; tdata: byte_offset, word_access, data_in
// out_    | out | out_tvalid/out_tready | tdata: read_data, irq, fetch_request, fetch_address
//
// One beat per cycle sustained while out_tready is high; an accepted beat passes
// through the input register into the result register and leaves from there.
// All register and sequencer updates happen as a beat moves from the input
// register into the result register.
// rst_n is synchronous, active low; it restores the register reset values and
// idles the sequencer.
// A stalled output holds its beat; one more input beat is taken into the input
// register while the result waits, then in_tready drops.
module lcd_controller_registers_frame_seq_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] mode
  input  logic [47:0] in_tdata,   // [9:0] byte_offset, [10] word_access, [42:11] data_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [31:0] read_data, [32] irq, [33] fetch_request,
                                  // [65:34] fetch_address
);
  import lcdfs_pkg::*;

  logic    in_valid_r;
  item_t   in_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t res;
  logic    out_free;
  logic    proc;

  // Advance the held beat when the result register is empty or being drained
  assign out_free  = !out_valid_r || out_tready;
  assign proc      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  // Capture the input beat; payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.mode        <= in_tuser;
      in_item_r.byte_offset <= in_tdata[9:0];
      in_item_r.word_access <= in_tdata[10];
      in_item_r.data_in     <= in_tdata[42:11];
    end
  end

  lcdfs_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .proc  (proc),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.fetch_address, out_res_r.fetch_request,
                       out_res_r.irq, out_res_r.read_data};

endmodule
